>>> src/avc_pkg.sv
`timescale 1ns / 1ps

package avc_pkg;

	// action codes
	localparam logic [1:0] ACT_CHECK = 2'd0;
	localparam logic [1:0] ACT_FILL  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// configuration register indexes
	localparam logic CFG_ENFORCING = 1'b0;
	localparam logic CFG_LIMIT     = 1'b1;

	localparam int LIMIT_W = 11;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd180;
	localparam int CLASS_SHIFT = 3;

	// one cached decision
	typedef struct packed {
		logic        valid;
		logic [15:0] cls;
		logic [31:0] label;
		logic [31:0] allowed;
		logic [31:0] audit_allow;
		logic [31:0] audit_deny;
		logic        hot;
		logic        perm;
		logic [31:0] create_label;
	} entry_t;

	typedef struct packed {
		logic        granted;
		logic [31:0] denied;
		logic [31:0] audited;
		logic [31:0] allowed;
	} decision_t;

	// decision for one entry, with the permissive merge into the allowed mask
	function automatic decision_t avc_decide(input entry_t e, input logic [31:0] req,
		input logic enforcing);
		decision_t d;
		d.denied  = req & ~e.allowed;
		d.audited = (d.denied != 32'd0) ? (d.denied & e.audit_deny) : (req & e.audit_allow);
		d.granted = 1'b1;
		d.allowed = e.allowed;
		if (d.denied != 32'd0) begin
			if (!enforcing || e.perm) begin
				d.allowed = e.allowed | req;
			end else begin
				d.granted = 1'b0;
			end
		end
		return d;
	endfunction

endpackage

>>> src/avc_row_mem.sv
`timescale 1ns / 1ps

module avc_row_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 716
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one row per set, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/access_vector_cache_check_core.sv
`timescale 1ns / 1ps
// steps: a check reads the set row on start, then compares, writes the row back on a hit
// and registers the result; flush and unused action register done straight from idle; a fill
// first sweeps sets (read, write) while over the limit, then reads the set row and writes it;
// one item at a time, busy high meanwhile; reset and flush: a clearing pass writes every
// set row, busy high; results are strobed by done for one cycle; the receiver cannot stall
module access_vector_cache_check_core #(
	parameter int NUM_SETS = 256,
	parameter int NUM_WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] object_label_id,
	input  logic [15:0] object_class,
	input  logic [31:0] required_perms,
	input  logic [31:0] fill_allowed,
	input  logic [31:0] fill_audit_allow,
	input  logic [31:0] fill_audit_deny,
	input  logic        fill_permissive,
	input  logic [31:0] fill_new_label,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	output logic        done,
	output logic        hit,
	output logic        granted,
	output logic [31:0] denied_perms,
	output logic [31:0] audited_perms,
	output logic        audit_is_denial,
	output logic [31:0] new_label
);

	localparam int SET_W = $clog2(NUM_SETS);
	localparam int CNT_W = $clog2(NUM_SETS * NUM_WAYS + 1);
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ENT_W = $bits(avc_pkg::entry_t);
	localparam int ROW_W = NUM_WAYS * ENT_W;
	localparam int RM_W  = $clog2(NUM_WAYS + 1);

	localparam logic [2:0] ST_CLR     = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_CHK     = 3'd2;
	localparam logic [2:0] ST_SW_RD   = 3'd3;
	localparam logic [2:0] ST_SW_WR   = 3'd4;
	localparam logic [2:0] ST_FILL_RD = 3'd5;
	localparam logic [2:0] ST_FILL    = 3'd6;

	logic [2:0]       state_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] hint_q;
	logic [CNT_W-1:0] count_q;
	logic             enforcing_q;
	logic [10:0]      limit_q;

	logic [31:0]      label_q;
	logic [15:0]      cls_q;
	logic [31:0]      req_q;
	logic [31:0]      fa_q;
	logic [31:0]      faa_q;
	logic [31:0]      fad_q;
	logic             fperm_q;
	logic [31:0]      fnew_q;
	logic [SET_W-1:0] set_q;

	logic             re;
	logic [SET_W-1:0] raddr;
	logic [ROW_W-1:0] rdata;
	logic             we;
	logic [SET_W-1:0] waddr;
	logic [ROW_W-1:0] wdata;

	avc_pkg::entry_t [NUM_WAYS-1:0] rd_row;
	avc_pkg::entry_t [NUM_WAYS-1:0] chk_row;
	avc_pkg::entry_t [NUM_WAYS-1:0] sw_row;
	avc_pkg::entry_t [NUM_WAYS-1:0] fill_row;
	avc_pkg::entry_t                fill_ent;
	avc_pkg::decision_t             chk_dec;
	avc_pkg::decision_t             fill_dec;

	logic [31:0]      in_key;
	logic [SET_W-1:0] in_set;
	logic [NUM_WAYS-1:0] match;
	logic             chk_hit;
	logic [WAY_W-1:0] chk_way;
	logic [WAY_W-1:0] fill_way;
	logic             fill_new;
	logic             found_inv;
	logic             found_cold;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] cold_way;
	logic [RM_W-1:0]  removed;
	logic [CNT_W-1:0] sw_count;
	logic             over_limit;
	logic             sw_over;

	assign busy = (state_q != ST_IDLE);

	// set index of the incoming key
	assign in_key = object_label_id ^ ({16'd0, object_class} << avc_pkg::CLASS_SHIFT);
	assign in_set = in_key[SET_W-1:0];
	assign rd_row = rdata;

	avc_row_mem #(
		.DEPTH(NUM_SETS),
		.WIDTH(ROW_W)
	) u_mem (
		.clk  (clk),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata)
	);

	// tag compare on the row read back
	always_comb begin
		match   = '0;
		chk_hit = 1'b0;
		chk_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			match[w] = rd_row[w].valid && (rd_row[w].cls == cls_q) && (rd_row[w].label == label_q);
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				chk_hit = 1'b1;
				chk_way = WAY_W'(w);
			end
		end
	end

	// check: mark hot and merge on a denial when permissive or not enforcing
	always_comb begin
		chk_row = rd_row;
		chk_dec = avc_pkg::avc_decide(rd_row[chk_way], req_q, enforcing_q);
		chk_row[chk_way].hot     = 1'b1;
		chk_row[chk_way].allowed = chk_dec.allowed;
	end

	// sweep: hot entries lose the hot bit, cold ones are dropped
	always_comb begin
		sw_row  = rd_row;
		removed = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rd_row[w].valid) begin
				if (rd_row[w].hot) begin
					sw_row[w].hot = 1'b0;
				end else begin
					sw_row[w].valid = 1'b0;
					removed = removed + RM_W'(1);
				end
			end
		end
		sw_count = (CNT_W'(removed) > count_q) ? '0 : (count_q - CNT_W'(removed));
	end

	assign over_limit = (count_q > CNT_W'(limit_q));
	assign sw_over    = (sw_count > CNT_W'(limit_q));

	// fill: matching way, else first free, else first cold, else way 0
	always_comb begin
		found_inv  = 1'b0;
		found_cold = 1'b0;
		inv_way    = '0;
		cold_way   = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!rd_row[w].valid) begin
				found_inv = 1'b1;
				inv_way   = WAY_W'(w);
			end
			if (!rd_row[w].hot) begin
				found_cold = 1'b1;
				cold_way   = WAY_W'(w);
			end
		end
		fill_new = 1'b0;
		if (chk_hit) begin
			fill_way = chk_way;
		end else if (found_inv) begin
			fill_way = inv_way;
			fill_new = 1'b1;
		end else if (found_cold) begin
			fill_way = cold_way;
		end else begin
			fill_way = '0;
		end
		fill_ent.valid        = 1'b1;
		fill_ent.cls          = cls_q;
		fill_ent.label        = label_q;
		fill_ent.allowed      = fa_q;
		fill_ent.audit_allow  = faa_q;
		fill_ent.audit_deny   = fad_q;
		fill_ent.hot          = 1'b1;
		fill_ent.perm         = fperm_q;
		fill_ent.create_label = fnew_q;
		fill_dec = avc_pkg::avc_decide(fill_ent, req_q, enforcing_q);
		fill_row = rd_row;
		fill_row[fill_way] = fill_ent;
		fill_row[fill_way].allowed = fill_dec.allowed;
	end

	// memory port control
	always_comb begin
		re    = 1'b0;
		raddr = in_set;
		we    = 1'b0;
		waddr = set_q;
		wdata = chk_row;
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				re    = start && (action == avc_pkg::ACT_CHECK);
				raddr = in_set;
			end
			ST_CHK: begin
				we = chk_hit;
			end
			ST_SW_RD: begin
				re    = 1'b1;
				raddr = hint_q;
			end
			ST_SW_WR: begin
				we    = 1'b1;
				waddr = hint_q;
				wdata = sw_row;
			end
			ST_FILL_RD: begin
				re    = 1'b1;
				raddr = set_q;
			end
			ST_FILL: begin
				we    = 1'b1;
				wdata = fill_row;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enforcing_q <= 1'b1;
			limit_q     <= avc_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				avc_pkg::CFG_ENFORCING: enforcing_q <= cfg_data[0];
				avc_pkg::CFG_LIMIT:     limit_q     <= cfg_data;
				default:                limit_q     <= limit_q;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			label_q <= object_label_id;
			cls_q   <= object_class;
			req_q   <= required_perms;
			fa_q    <= fill_allowed;
			faa_q   <= fill_audit_allow;
			fad_q   <= fill_audit_deny;
			fperm_q <= fill_permissive;
			fnew_q  <= fill_new_label;
			set_q   <= in_set;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLR;
			clr_q           <= '0;
			hint_q          <= '0;
			count_q         <= '0;
			done            <= 1'b0;
			hit             <= 1'b0;
			granted         <= 1'b0;
			denied_perms    <= '0;
			audited_perms   <= '0;
			audit_is_denial <= 1'b0;
			new_label       <= '0;
		end else begin
			done            <= 1'b0;
			hit             <= 1'b0;
			granted         <= 1'b0;
			denied_perms    <= '0;
			audited_perms   <= '0;
			audit_is_denial <= 1'b0;
			new_label       <= '0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(NUM_SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (action)
							avc_pkg::ACT_CHECK: state_q <= ST_CHK;
							avc_pkg::ACT_FILL: begin
								state_q <= over_limit ? ST_SW_RD : ST_FILL_RD;
							end
							avc_pkg::ACT_FLUSH: begin
								done    <= 1'b1;
								count_q <= '0;
								hint_q  <= '0;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				ST_CHK: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
					if (chk_hit) begin
						hit             <= 1'b1;
						granted         <= chk_dec.granted;
						denied_perms    <= chk_dec.denied;
						audited_perms   <= chk_dec.audited;
						audit_is_denial <= (chk_dec.denied != 32'd0);
						new_label       <= rd_row[chk_way].create_label;
					end
				end
				ST_SW_RD: begin
					state_q <= ST_SW_WR;
				end
				ST_SW_WR: begin
					count_q <= sw_count;
					hint_q  <= hint_q + SET_W'(1);
					state_q <= sw_over ? ST_SW_RD : ST_FILL_RD;
				end
				ST_FILL_RD: begin
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (fill_new) begin
						count_q <= count_q + CNT_W'(1);
					end
					done            <= 1'b1;
					hit             <= 1'b1;
					granted         <= fill_dec.granted;
					denied_perms    <= fill_dec.denied;
					audited_perms   <= fill_dec.audited;
					audit_is_denial <= (fill_dec.denied != 32'd0);
					new_label       <= fnew_q;
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> dv/avc_decision_checker.sv
`timescale 1ns / 1ps

module avc_decision_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] object_label_id,
	input  logic [15:0] object_class,
	input  logic [31:0] required_perms,
	input  logic [31:0] fill_allowed,
	input  logic [31:0] fill_audit_allow,
	input  logic [31:0] fill_audit_deny,
	input  logic        fill_permissive,
	input  logic [31:0] fill_new_label,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        done,
	input  logic        hit,
	input  logic        granted,
	input  logic [31:0] denied_perms,
	input  logic [31:0] audited_perms,
	input  logic        audit_is_denial,
	input  logic [31:0] new_label,
	output int          fail_count,
	output int          pending,
	output int          hit_count
);

	localparam int SETS = 256;
	localparam int WAYS = 4;

	typedef struct packed {
		logic        hit;
		logic        granted;
		logic [31:0] denied;
		logic [31:0] audited;
		logic        is_denial;
		logic [31:0] new_label;
	} decision_t;

	// cached decision store, one copy per way
	logic        c_valid [SETS*WAYS];
	logic [15:0] c_cls [SETS*WAYS];
	logic [31:0] c_label [SETS*WAYS];
	logic [31:0] c_allowed [SETS*WAYS];
	logic [31:0] c_aud_allow [SETS*WAYS];
	logic [31:0] c_aud_deny [SETS*WAYS];
	logic        c_hot [SETS*WAYS];
	logic        c_perm [SETS*WAYS];
	logic [31:0] c_create [SETS*WAYS];
	int          occupancy;
	int          sweep_pos;
	logic        enforce;
	logic [10:0] limit;

	decision_t expected_decisions [$];

	// decision on one entry, granting and merging when permissive or not enforcing
	function automatic decision_t judge(int e, logic [31:0] req);
		decision_t d;
		d = '0;
		d.hit = 1'b1;
		d.granted = 1'b1;
		d.denied = req & ~c_allowed[e];
		d.is_denial = (d.denied != 0);
		d.audited = d.is_denial ? (d.denied & c_aud_deny[e]) : (req & c_aud_allow[e]);
		d.new_label = c_create[e];
		if (d.is_denial) begin
			if (!enforce || c_perm[e])
				c_allowed[e] = c_allowed[e] | req;
			else
				d.granted = 1'b0;
		end
		return d;
	endfunction

	function automatic int lookup(int s, logic [31:0] lbl, logic [15:0] cl);
		for (int w = 0; w < WAYS; w++)
			if (c_valid[s*WAYS+w] && c_label[s*WAYS+w] == lbl && c_cls[s*WAYS+w] == cl)
				return s*WAYS + w;
		return -1;
	endfunction

	// second-chance reclaim while over the limit
	function automatic void reclaim();
		while (occupancy > int'(limit)) begin
			for (int w = 0; w < WAYS; w++) begin
				int e;
				e = sweep_pos*WAYS + w;
				if (c_valid[e]) begin
					if (c_hot[e]) begin
						c_hot[e] = 1'b0;
					end else begin
						c_valid[e] = 1'b0;
						occupancy--;
					end
				end
			end
			sweep_pos = (sweep_pos + 1) % SETS;
		end
	endfunction

	function automatic decision_t predict_decision();
		decision_t d;
		logic [31:0] key;
		int s;
		int e;
		int pick;
		d = '0;
		key = object_label_id ^ ({16'd0, object_class} << avc_pkg::CLASS_SHIFT);
		s = int'(key % SETS);
		case (action)
			avc_pkg::ACT_CHECK: begin
				e = lookup(s, object_label_id, object_class);
				if (e >= 0) begin
					c_hot[e] = 1'b1;
					d = judge(e, required_perms);
				end
			end
			avc_pkg::ACT_FILL: begin
				reclaim();
				e = lookup(s, object_label_id, object_class);
				if (e < 0) begin
					pick = -1;
					for (int w = 0; w < WAYS && pick < 0; w++)
						if (!c_valid[s*WAYS+w]) pick = w;
					if (pick >= 0) begin
						occupancy++;
					end else begin
						for (int w = 0; w < WAYS && pick < 0; w++)
							if (!c_hot[s*WAYS+w]) pick = w;
						if (pick < 0) pick = 0;
					end
					e = s*WAYS + pick;
				end
				c_valid[e] = 1'b1;
				c_label[e] = object_label_id;
				c_cls[e] = object_class;
				c_allowed[e] = fill_allowed;
				c_aud_allow[e] = fill_audit_allow;
				c_aud_deny[e] = fill_audit_deny;
				c_hot[e] = 1'b1;
				c_perm[e] = fill_permissive;
				c_create[e] = fill_new_label;
				d = judge(e, required_perms);
			end
			avc_pkg::ACT_FLUSH: begin
				for (int i = 0; i < SETS*WAYS; i++) c_valid[i] = 1'b0;
				occupancy = 0;
				sweep_pos = 0;
			end
			default: ;
		endcase
		return d;
	endfunction

	// result compare, register tracking and expectation per transfer
	always @(posedge clk or negedge arst_n) begin
		decision_t exp_d;
		if (!arst_n) begin
			for (int i = 0; i < SETS*WAYS; i++) c_valid[i] = 1'b0;
			occupancy = 0;
			sweep_pos = 0;
			enforce = 1'b1;
			limit = avc_pkg::LIMIT_RESET;
			expected_decisions.delete();
			fail_count = 0;
			hit_count = 0;
		end else begin
			if (done) begin
				if (expected_decisions.size() == 0) begin
					$error("result with no transfer outstanding");
					fail_count++;
				end else begin
					exp_d = expected_decisions.pop_front();
					if (hit !== exp_d.hit) begin
						$error("hit exp %0h got %0h", exp_d.hit, hit);
						fail_count++;
					end
					if (granted !== exp_d.granted) begin
						$error("granted exp %0h got %0h", exp_d.granted, granted);
						fail_count++;
					end
					if (denied_perms !== exp_d.denied) begin
						$error("denied_perms exp %h got %h", exp_d.denied, denied_perms);
						fail_count++;
					end
					if (audited_perms !== exp_d.audited) begin
						$error("audited_perms exp %h got %h", exp_d.audited, audited_perms);
						fail_count++;
					end
					if (audit_is_denial !== exp_d.is_denial) begin
						$error("audit_is_denial exp %0h got %0h", exp_d.is_denial,
							audit_is_denial);
						fail_count++;
					end
					if (new_label !== exp_d.new_label) begin
						$error("new_label exp %h got %h", exp_d.new_label, new_label);
						fail_count++;
					end
					if (exp_d.hit) hit_count++;
				end
			end
			if (cfg_we) begin
				if (cfg_index == avc_pkg::CFG_ENFORCING)
					enforce = cfg_data[0];
				else
					limit = cfg_data;
			end
			if (start && !busy)
				expected_decisions.push_back(predict_decision());
		end
		pending = expected_decisions.size();
	end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int POOL = 128;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = avc_pkg::ACT_CHECK;
	logic [31:0] object_label_id = '0;
	logic [15:0] object_class = '0;
	logic [31:0] required_perms = '0;
	logic [31:0] fill_allowed = '0;
	logic [31:0] fill_audit_allow = '0;
	logic [31:0] fill_audit_deny = '0;
	logic        fill_permissive = 1'b0;
	logic [31:0] fill_new_label = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = avc_pkg::CFG_ENFORCING;
	logic [10:0] cfg_data = '0;
	logic        done;
	logic        hit;
	logic        granted;
	logic [31:0] denied_perms;
	logic [31:0] audited_perms;
	logic        audit_is_denial;
	logic [31:0] new_label;
	int          fail_count;
	int          pending;
	int          hit_count;

	logic [31:0] key_label [POOL];
	logic [15:0] key_class [POOL];
	int          transfers = 0;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	access_vector_cache_check_core dut (.*);

	avc_decision_checker checker_i (.*);

	// watchdog on cycles with no transfer and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one, often none
	task automatic gap();
		int n;
		n = ($urandom_range(0, 99) < 50) ? 0 :
			($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// present one item and hold it until the transfer
	task automatic issue(logic [1:0] act, logic [31:0] lbl, logic [15:0] cl,
		logic [31:0] req, logic [31:0] alw, logic [31:0] aa, logic [31:0] ad,
		logic perm, logic [31:0] nl);
		start <= 1'b1;
		action <= act;
		object_label_id <= lbl;
		object_class <= cl;
		required_perms <= req;
		fill_allowed <= alw;
		fill_audit_allow <= aa;
		fill_audit_deny <= ad;
		fill_permissive <= perm;
		fill_new_label <= nl;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		transfers++;
		gap();
	endtask

	task automatic fill_key(int k, logic [31:0] req);
		issue(avc_pkg::ACT_FILL, key_label[k], key_class[k], req, $urandom | $urandom,
			$urandom, $urandom, $urandom_range(0, 3) == 0, $urandom);
	endtask

	task automatic check_key(int k, logic [31:0] req);
		issue(avc_pkg::ACT_CHECK, key_label[k], key_class[k], req, $urandom, $urandom,
			$urandom, 1'($urandom_range(0, 1)), $urandom);
	endtask

	// wait for every result and for the clearing pass before a register write
	task automatic quiesce();
		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0 && !busy) break;
		end
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [10:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_req();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom & $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [10:0] limits [6];
		logic        modes [6];
		int k;
		int r;
		limits = '{11'd180, 11'd1, 11'd1024, 11'd8, 11'd0, 11'd40};
		modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

		// key pool crowded onto 20 sets so that ways fill up
		for (int i = 0; i < POOL; i++) begin
			key_class[i] = 16'($urandom);
			key_label[i] = $urandom;
			key_label[i][7:0] = 8'(i % 20) ^
				8'({16'd0, key_class[i]} << avc_pkg::CLASS_SHIFT);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		quiesce();

		// directed: extremes, every action, misses and set overflow
		write_reg(avc_pkg::CFG_ENFORCING, 11'd1);
		write_reg(avc_pkg::CFG_LIMIT, avc_pkg::LIMIT_RESET);
		issue(avc_pkg::ACT_CHECK, '1, '1, '1, '0, '0, '0, 1'b0, '0);
		issue(avc_pkg::ACT_FILL, '1, '1, '1, '0, '1, '1, 1'b0, '1);
		issue(avc_pkg::ACT_CHECK, '1, '1, '1, '1, '1, '1, 1'b1, '1);
		issue(avc_pkg::ACT_CHECK, '1, '1, '0, '0, '0, '0, 1'b0, '0);
		issue(avc_pkg::ACT_FILL, '0, '0, '0, '1, '0, '0, 1'b1, '0);
		issue(avc_pkg::ACT_CHECK, '0, '0, '1, '0, '0, '0, 1'b0, '0);
		issue(avc_pkg::ACT_FILL, '0, '0, '1, 32'h0000_ffff, '1, '1, 1'b1, 32'h1234_5678);
		issue(avc_pkg::ACT_CHECK, '0, '0, '1, '0, '0, '0, 1'b0, '0);
		issue(2'd3, '1, '1, '1, '1, '1, '1, 1'b1, '1);
		for (int i = 0; i < 6; i++) fill_key(i * 20, rand_req());
		for (int i = 0; i < 6; i++) check_key(i * 20, rand_req());
		issue(avc_pkg::ACT_FLUSH, '0, '0, '0, '0, '0, '0, 1'b0, '0);
		check_key(0, '1);

		// random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			quiesce();
			write_reg(avc_pkg::CFG_ENFORCING, {10'd0, modes[p]});
			write_reg(avc_pkg::CFG_LIMIT, limits[p]);
			for (int n = 0; n < 78; n++) begin
				r = $urandom_range(0, 99);
				k = $urandom_range(0, POOL - 1);
				if (r < 8) begin
					issue(2'($urandom_range(0, 3)), $urandom, 16'($urandom), $urandom,
						$urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
				end else if (r < 10) begin
					issue(avc_pkg::ACT_FLUSH, $urandom, 16'($urandom), $urandom, '0, '0, '0,
						1'b0, '0);
				end else if (r < 25) begin
					issue(avc_pkg::ACT_FILL, $urandom, 16'($urandom), rand_req(),
						$urandom | $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
						$urandom);
				end else begin
					check_key(k, rand_req());
					if ($urandom_range(0, 1)) fill_key(k, rand_req());
					check_key(k, rand_req());
				end
			end
		end

		quiesce();
		repeat (300) @(posedge clk);
		$display("covered %0d transfers over 6 register settings, %0d cache hits",
			transfers, hit_count);
		$display("checked against predicted decisions, %0d mismatches", fail_count);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
